// File: hdl/agrs_pkg.sv
// Shared types, codes and field widths for the alignment gap rank/select block.
package agrs_pkg;

  // Field widths of the transaction payloads and configuration registers
  localparam int MODE_W     = 2;
  localparam int SEQ_W      = 6;
  localparam int POS_W      = 11;
  localparam int VALUE_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int ALEN_W     = 12;
  localparam int SCNT_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Default sizes of the gap store
  localparam int DEF_MAX_COLUMNS   = 2048;
  localparam int DEF_MAX_SEQUENCES = 64;

  // Register reset values
  localparam logic [ALEN_W-1:0] ALEN_RESET = 12'd2048;
  localparam logic [SCNT_W-1:0] SCNT_RESET = 7'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_SEQ_POS = 2'd1,
    MODE_ALN_COL = 2'd2,
    MODE_NET_LEN = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_GAP       = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_BAD_POS   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIGNMENT_LENGTH = 1'd0,
    CFG_SEQUENCE_COUNT   = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WR_READ,
    S_WR_MOD,
    S_SCAN
  } state_t;

endpackage

// File: hdl/agrs_if.sv
// Valid/ready channel interfaces for command and result transactions.
interface agrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [agrs_pkg::MODE_W-1:0] mode;
  logic [agrs_pkg::SEQ_W-1:0]  seq_index;
  logic [agrs_pkg::POS_W-1:0]  position;
  logic                       is_gap;

  modport source (output valid, output mode, output seq_index, output position,
                  output is_gap, input ready);
  modport sink   (input valid, input mode, input seq_index, input position,
                  input is_gap, output ready);
endinterface

interface agrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [agrs_pkg::VALUE_W-1:0]  value;
  logic [agrs_pkg::STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// File: hdl/agrs_gap_ram.sv
// Gap map store: one word per column, one write port, one registered read port.
module agrs_gap_ram #(
  parameter int DEPTH = agrs_pkg::DEF_MAX_COLUMNS,
  parameter int WIDTH = agrs_pkg::DEF_MAX_SEQUENCES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/alignment_gap_rank_select.sv
// Alignment gap map with sequence-position, column-select and net-length queries.
//
// Commands arrive on in_ch (valid/ready); each accepted one yields exactly one result
// on out_ch with value and status. cfg_we/cfg_index/cfg_data set alignment_length and
// sequence_count; the user must write them only while idle, unenforced by the block.
//
// A gap-bit write is a read-modify-write of one column word. A query walks the gap
// store one column per cycle through a single counter/comparator, fed by the
// store's registered read port: sequence position takes position+1 columns, net
// length takes the effective column count, and column select stops at the column
// that holds the requested residue (at most the effective column count). A write's
// result is registered after the read and modify states; a query's result is
// registered as the last column walked is counted. A command rejected for a bad
// index or position has its result registered at the accepting edge.
//
// One command is in work at a time: in_ch.ready is high only when the block is
// idle and the result register is empty, so a stalled receiver holds off the next
// command. Reset (rst_n, synchronous) clears the sequencer, the result register and
// the configuration; the gap store itself is not cleared and must be written
// before it is queried.
module alignment_gap_rank_select #(
  parameter int MAX_COLUMNS   = agrs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_SEQUENCES = agrs_pkg::DEF_MAX_SEQUENCES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  agrs_in_if.sink                        in_ch,
  agrs_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [agrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agrs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int SEQ_AW = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int LEN_W  = ($clog2(MAX_COLUMNS + 1) > agrs_pkg::ALEN_W) ?
                          $clog2(MAX_COLUMNS + 1) : agrs_pkg::ALEN_W;
  localparam logic [LEN_W-1:0] MAX_COLS_L = LEN_W'(MAX_COLUMNS);
  localparam logic [agrs_pkg::SCNT_W-1:0] MAX_SEQS_L = agrs_pkg::SCNT_W'(MAX_SEQUENCES);

  // Configuration
  logic [agrs_pkg::ALEN_W-1:0] aln_len_r;
  logic [agrs_pkg::SCNT_W-1:0] seq_cnt_r;

  // Sequencer and command registers
  agrs_pkg::state_t state_r, state_nxt;
  agrs_pkg::mode_t  mode_r, mode_nxt;
  logic [SEQ_AW-1:0] seq_r, seq_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              gap_r, gap_nxt;
  logic [LEN_W-1:0]  end_r, end_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  issue_r, issue_nxt;
  logic [LEN_W-1:0]  proc_r, proc_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;

  // Result register
  logic                          out_valid_r, out_valid_nxt;
  logic [agrs_pkg::VALUE_W-1:0]  res_value_r, res_value_nxt;
  agrs_pkg::status_t             res_status_r, res_status_nxt;

  // Store ports
  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [MAX_SEQUENCES-1:0] ram_rdata;
  logic [MAX_SEQUENCES-1:0] ram_wdata;

  // Decode
  logic                        in_ready;
  logic                        in_fire;
  logic                        out_fire;
  agrs_pkg::mode_t             in_mode;
  logic [LEN_W-1:0]            in_pos;
  logic [LEN_W-1:0]            eff_len;
  logic [agrs_pkg::SCNT_W-1:0] eff_seqs;
  logic                        wr_bad_idx, wr_bad_pos;
  logic                        q_bad_idx, q_bad_pos;
  logic                        issue;
  logic                        col_bit, hit;
  logic [LEN_W-1:0]            cnt_sum;
  logic                        scan_last;
  logic [LEN_W-1:0]            scan_value;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign in_mode  = agrs_pkg::mode_t'(in_ch.mode);
  assign in_pos   = LEN_W'(in_ch.position);

  // Out-of-range lengths fall back to the full store
  assign eff_len  = (aln_len_r == '0 || LEN_W'(aln_len_r) > MAX_COLS_L) ?
                    MAX_COLS_L : LEN_W'(aln_len_r);
  assign eff_seqs = (seq_cnt_r > MAX_SEQS_L) ? MAX_SEQS_L : seq_cnt_r;

  assign wr_bad_idx = {1'b0, in_ch.seq_index} >= MAX_SEQS_L;
  assign wr_bad_pos = in_pos >= MAX_COLS_L;
  assign q_bad_idx  = {1'b0, in_ch.seq_index} >= eff_seqs;
  assign q_bad_pos  = (in_mode != agrs_pkg::MODE_NET_LEN) && (in_pos >= eff_len);

  // Shared scan unit: one column bit, one count add, one stop compare per cycle
  assign col_bit = ram_rdata[seq_r];
  assign hit     = (mode_r == agrs_pkg::MODE_ALN_COL) ? !col_bit : col_bit;
  assign cnt_sum = cnt_r + LEN_W'(hit);
  assign scan_last = (state_r == agrs_pkg::S_SCAN) && rd_vld_r &&
                     ((proc_r == end_r - LEN_W'(1)) ||
                      ((mode_r == agrs_pkg::MODE_ALN_COL) && hit && (cnt_r == pos_r)));

  always_comb begin
    case (mode_r)
      agrs_pkg::MODE_NET_LEN: scan_value = len_r - cnt_sum;
      agrs_pkg::MODE_ALN_COL: scan_value = proc_r;
      default:                scan_value = pos_r - cnt_r;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      agrs_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_mode == agrs_pkg::MODE_WRITE) begin
            if (!wr_bad_idx && !wr_bad_pos) state_nxt = agrs_pkg::S_WR_READ;
          end else if (!q_bad_idx && !q_bad_pos) begin
            state_nxt = agrs_pkg::S_SCAN;
          end
        end
      end
      agrs_pkg::S_WR_READ: state_nxt = agrs_pkg::S_WR_MOD;
      agrs_pkg::S_WR_MOD:  state_nxt = agrs_pkg::S_IDLE;
      agrs_pkg::S_SCAN: begin
        if (scan_last) state_nxt = agrs_pkg::S_IDLE;
      end
      default: state_nxt = agrs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = (state_r == agrs_pkg::S_IDLE) && !out_valid_r;
    issue     = (state_r == agrs_pkg::S_SCAN) && (issue_r < end_r);
    ram_raddr = (state_r == agrs_pkg::S_SCAN) ? issue_r[AW-1:0] : pos_r[AW-1:0];
    ram_we    = (state_r == agrs_pkg::S_WR_MOD);
    ram_wdata = ram_rdata;
    ram_wdata[seq_r] = gap_r;
  end

  // Datapath
  always_comb begin
    mode_nxt       = mode_r;
    seq_nxt        = seq_r;
    pos_nxt        = pos_r;
    gap_nxt        = gap_r;
    end_nxt        = end_r;
    len_nxt        = len_r;
    issue_nxt      = issue_r;
    proc_nxt       = proc_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = issue;
    out_valid_nxt  = out_valid_r && !out_fire;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;

    if (in_fire) begin
      mode_nxt  = in_mode;
      seq_nxt   = in_ch.seq_index[SEQ_AW-1:0];
      pos_nxt   = in_pos;
      gap_nxt   = in_ch.is_gap;
      len_nxt   = eff_len;
      end_nxt   = (in_mode == agrs_pkg::MODE_SEQ_POS) ? in_pos + LEN_W'(1) : eff_len;
      issue_nxt = '0;
      proc_nxt  = '0;
      cnt_nxt   = '0;
      res_value_nxt = '0;
      // Rejected commands answer at once
      if (in_mode == agrs_pkg::MODE_WRITE) begin
        if (wr_bad_idx) begin
          res_status_nxt = agrs_pkg::STAT_BAD_INDEX;
          out_valid_nxt  = 1'b1;
        end else if (wr_bad_pos) begin
          res_status_nxt = agrs_pkg::STAT_BAD_POS;
          out_valid_nxt  = 1'b1;
        end
      end else if (q_bad_idx) begin
        res_status_nxt = agrs_pkg::STAT_BAD_INDEX;
        out_valid_nxt  = 1'b1;
      end else if (q_bad_pos) begin
        res_status_nxt = agrs_pkg::STAT_BAD_POS;
        out_valid_nxt  = 1'b1;
      end
    end

    if (state_r == agrs_pkg::S_WR_MOD) begin
      res_value_nxt  = '0;
      res_status_nxt = agrs_pkg::STAT_OK;
      out_valid_nxt  = 1'b1;
    end

    if (issue) issue_nxt = issue_r + LEN_W'(1);

    if ((state_r == agrs_pkg::S_SCAN) && rd_vld_r) begin
      proc_nxt = proc_r + LEN_W'(1);
      cnt_nxt  = cnt_sum;
    end

    if (scan_last) begin
      out_valid_nxt = 1'b1;
      if ((mode_r == agrs_pkg::MODE_SEQ_POS) && col_bit) begin
        res_value_nxt  = '0;
        res_status_nxt = agrs_pkg::STAT_GAP;
      end else begin
        res_value_nxt  = scan_value[agrs_pkg::VALUE_W-1:0];
        res_status_nxt = agrs_pkg::STAT_OK;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= agrs_pkg::S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      aln_len_r   <= agrs_pkg::ALEN_RESET;
      seq_cnt_r   <= agrs_pkg::SCNT_RESET;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (agrs_pkg::cfg_reg_t'(cfg_index))
          agrs_pkg::CFG_ALIGNMENT_LENGTH: aln_len_r <= cfg_data[agrs_pkg::ALEN_W-1:0];
          agrs_pkg::CFG_SEQUENCE_COUNT:   seq_cnt_r <= cfg_data[agrs_pkg::SCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    seq_r        <= seq_nxt;
    pos_r        <= pos_nxt;
    gap_r        <= gap_nxt;
    end_r        <= end_nxt;
    len_r        <= len_nxt;
    issue_r      <= issue_nxt;
    proc_r       <= proc_nxt;
    cnt_r        <= cnt_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  agrs_gap_ram #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (MAX_SEQUENCES),
    .AW    (AW)
  ) u_gap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = res_value_r;
  assign out_ch.status = res_status_r;

  // Only one command in work: never ready while a result is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  // A taken result is not followed by another without a new command
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> !out_ch.valid)
    else $error("result repeated after transaction");

  // The read counter never runs past the scan range
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == agrs_pkg::S_SCAN) |-> (issue_r <= end_r))
    else $error("scan read past the end column");

  // Error and gap answers carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != agrs_pkg::STAT_OK)) |-> (out_ch.value == '0))
    else $error("non-zero value with error status");

endmodule
